FILE: design/erq_pkg.sv
// shared constants, types and the arctangent table for the angle to quaternion block
// no dependencies
package erq_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int TABLE_LEN     = 24;
    localparam int NSTEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int ANG_W = 15;
    localparam int XY_W  = 33;
    localparam int Z_W   = 34;
    localparam int Q_W   = 16;

    localparam logic signed [XY_W-1:0] KINV_Q30 = XY_W'(652032874);
    localparam logic signed [Z_W-1:0]  DEG90    = Z_W'(1509949440);

    typedef struct packed {
        logic signed [XY_W-1:0] s;
        logic signed [XY_W-1:0] c;
    } t_sincos;

    function automatic logic signed [Z_W-1:0] atan_deg24(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = Z_W'(754974720);
            1:  v = Z_W'(445687602);
            2:  v = Z_W'(235489088);
            3:  v = Z_W'(119537938);
            4:  v = Z_W'(60000934);
            5:  v = Z_W'(30029717);
            6:  v = Z_W'(15018523);
            7:  v = Z_W'(7509720);
            8:  v = Z_W'(3754917);
            9:  v = Z_W'(1877466);
            10: v = Z_W'(938734);
            11: v = Z_W'(469367);
            12: v = Z_W'(234684);
            13: v = Z_W'(117342);
            14: v = Z_W'(58671);
            15: v = Z_W'(29335);
            16: v = Z_W'(14668);
            17: v = Z_W'(7334);
            18: v = Z_W'(3667);
            19: v = Z_W'(1833);
            20: v = Z_W'(917);
            21: v = Z_W'(458);
            22: v = Z_W'(229);
            default: v = Z_W'(115);
        endcase
        return v;
    endfunction

endpackage

FILE: design/erq_lane.sv
// pipelined rotation cordic: half angle sine and cosine in q2.30
// depends on erq_pkg
module erq_lane import erq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_angle,
    output t_sincos                 o_sc
);

    logic signed [XY_W-1:0] r_x [0:NSTEPS];
    logic signed [XY_W-1:0] r_y [0:NSTEPS];
    logic signed [Z_W-1:0]  r_z [0:NSTEPS];

    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] n_x0, n_y0;
    logic signed [Z_W-1:0]  n_z0;

    // half angle in degrees * 2^24
    assign z_in = {{(Z_W-ANG_W-17){i_angle[ANG_W-1]}}, i_angle, 17'd0};

    always_comb begin
        n_x0 = KINV_Q30;
        n_y0 = '0;
        n_z0 = z_in;
        if (z_in > DEG90) begin
            n_x0 = '0;
            n_y0 = KINV_Q30;
            n_z0 = z_in - DEG90;
        end else if (z_in < -DEG90) begin
            n_x0 = '0;
            n_y0 = -KINV_Q30;
            n_z0 = z_in + DEG90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar g = 0; g < NSTEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][Z_W-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_deg24(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_deg24(g);
                end
            end
        end
    end

    assign o_sc.s = r_y[NSTEPS];
    assign o_sc.c = r_x[NSTEPS];

endmodule

FILE: design/erq_merge.sv
// merge stage: triple products of the three lanes, sums, rounding and saturation
// depends on erq_pkg
module erq_merge import erq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_sincos               i_r,
    input  t_sincos               i_p,
    input  t_sincos               i_y,
    output logic signed [Q_W-1:0] o_x,
    output logic signed [Q_W-1:0] o_y,
    output logic signed [Q_W-1:0] o_z,
    output logic signed [Q_W-1:0] o_w
);

    localparam int P_W  = 36;
    localparam int T_W  = 68;
    localparam int SH   = 60 - OUT_FRAC_BITS;
    localparam logic signed [T_W-1:0] LIM  = T_W'(1) <<< OUT_FRAC_BITS;
    localparam logic signed [T_W-1:0] HALF = T_W'(1) <<< (SH - 1);
    localparam logic signed [2*XY_W-1:0] RND = (2*XY_W)'(1) <<< 29;

    logic signed [P_W-1:0]  r_srcp, r_crsp, r_crcp, r_srsp;
    logic signed [XY_W-1:0] r_sy, r_cy;
    logic signed [T_W-1:0]  r_t [0:7];

    function automatic logic signed [P_W-1:0] pair(input logic signed [XY_W-1:0] a,
                                                    input logic signed [XY_W-1:0] b);
        logic signed [2*XY_W-1:0] m;
        m = a * b + RND;
        return P_W'(m >>> 30);
    endfunction

    function automatic logic signed [T_W-1:0] mul3(input logic signed [P_W-1:0] p,
                                                    input logic signed [XY_W-1:0] c);
        logic signed [T_W-1:0] pe, ce;
        pe = T_W'(p);
        ce = T_W'(c);
        return pe * ce;
    endfunction

    function automatic logic signed [Q_W-1:0] fin(input logic signed [T_W-1:0] q);
        logic signed [T_W-1:0] v;
        v = (q + HALF) >>> SH;
        if (v > LIM) v = LIM;
        if (v < -LIM) v = -LIM;
        return v[Q_W-1:0];
    endfunction

    // roll and pitch are paired and rounded first, yaw is the third factor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_srcp <= pair(i_r.s, i_p.c);
            r_crsp <= pair(i_r.c, i_p.s);
            r_crcp <= pair(i_r.c, i_p.c);
            r_srsp <= pair(i_r.s, i_p.s);
            r_sy   <= i_y.s;
            r_cy   <= i_y.c;
            r_t[0] <= mul3(r_srcp, r_cy);
            r_t[1] <= mul3(r_crsp, r_sy);
            r_t[2] <= mul3(r_crsp, r_cy);
            r_t[3] <= mul3(r_srcp, r_sy);
            r_t[4] <= mul3(r_crcp, r_sy);
            r_t[5] <= mul3(r_srsp, r_cy);
            r_t[6] <= mul3(r_crcp, r_cy);
            r_t[7] <= mul3(r_srsp, r_sy);
        end
    end

    assign o_x = fin(r_t[0] - r_t[1]);
    assign o_y = fin(r_t[2] + r_t[3]);
    assign o_z = fin(r_t[4] - r_t[5]);
    assign o_w = fin(r_t[6] + r_t[7]);

endmodule

FILE: design/euler_rpy_to_quaternion.sv
// top level: three cordic lanes, merge stage, output register and flow control
// depends on erq_pkg, erq_lane, erq_merge
// Roll, pitch and yaw (1/64 degree) in, unit Z-Y-X quaternion in Q1.14 out. One beat is
// accepted per cycle while o_stall is low; the path holds one pre-rotation register, one
// register per cordic step, two product registers in the merge and one output register.
// When the output is stalled the pipeline keeps moving until its last stage holds a beat,
// so a beat is still taken while a result waits.
module euler_rpy_to_quaternion import erq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [ANG_W-1:0] i_roll_angle,
    input  logic signed [ANG_W-1:0] i_pitch_angle,
    input  logic signed [ANG_W-1:0] i_yaw_angle,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [Q_W-1:0]   o_quat_x,
    output logic signed [Q_W-1:0]   o_quat_y,
    output logic signed [Q_W-1:0]   o_quat_z,
    output logic signed [Q_W-1:0]   o_quat_w
);

    localparam int DEPTH = NSTEPS + 3;

    logic [DEPTH-1:0]      r_v;
    logic                  en, out_load;
    t_sincos               sc_r, sc_p, sc_y;
    logic signed [Q_W-1:0] m_x, m_y, m_z, m_w;
    logic signed [Q_W-1:0] r_qx, r_qy, r_qz, r_qw;
    logic                  r_out_valid;

    assign out_load = !r_out_valid || !i_stall;
    assign en       = out_load || !r_v[DEPTH-1];
    assign o_stall  = !en;

    erq_lane u_roll  (.i_clk(i_clk), .i_en(en), .i_angle(i_roll_angle),  .o_sc(sc_r));
    erq_lane u_pitch (.i_clk(i_clk), .i_en(en), .i_angle(i_pitch_angle), .o_sc(sc_p));
    erq_lane u_yaw   (.i_clk(i_clk), .i_en(en), .i_angle(i_yaw_angle),   .o_sc(sc_y));

    erq_merge u_merge (
        .i_clk(i_clk), .i_en(en), .i_r(sc_r), .i_p(sc_p), .i_y(sc_y),
        .o_x(m_x), .o_y(m_y), .o_z(m_z), .o_w(m_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) r_v <= {r_v[DEPTH-2:0], i_valid};
            if (out_load) r_out_valid <= r_v[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_qx <= m_x;
            r_qy <= m_y;
            r_qz <= m_z;
            r_qw <= m_w;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;

    localparam logic signed [Q_W-1:0] QLIM = Q_W'(1 << OUT_FRAC_BITS);

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && r_v[DEPTH-1]))
        else $error("input stalled with room in the pipeline");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_w_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && OUT_FRAC_BITS <= 14) |-> (o_quat_w <= QLIM && o_quat_w >= -QLIM))
        else $error("scalar component out of range");

endmodule

FILE: tb/sv/euler_rpy_to_quaternion_tb.sv
// self-checking testbench for euler_rpy_to_quaternion: directed and random angle triples
// depends on erq_pkg and the euler_rpy_to_quaternion rtl
module euler_rpy_to_quaternion_tb;
    import erq_pkg::*;

    typedef struct {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        bit                      drain;  // hold this beat until every result is back
    } t_angles;

    typedef struct {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
        logic signed [Q_W-1:0] w;
    } t_quat;

    localparam int LIMIT_CYCLES = 600000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [ANG_W-1:0] i_roll_angle = '0;
    logic signed [ANG_W-1:0] i_pitch_angle = '0;
    logic signed [ANG_W-1:0] i_yaw_angle = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [Q_W-1:0]   o_quat_x;
    logic signed [Q_W-1:0]   o_quat_y;
    logic signed [Q_W-1:0]   o_quat_z;
    logic signed [Q_W-1:0]   o_quat_w;

    t_angles pending_angles[$];
    t_quat   expected_quats[$];
    int      errors = 0;
    int      cycles = 0;
    int      beats_out = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    bit      calm_tx = 1'b0;
    bit      calm_rx = 1'b0;

    longint atan_tab[TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115
    };

    euler_rpy_to_quaternion i_dut (.*);

    always #5 i_clk = ~i_clk;

    // cordic on the half angle, sine and cosine in q2.30
    function automatic void half_angle_sincos(input logic signed [ANG_W-1:0] ang,
                                              output longint s, output longint c);
        longint z, x, y, t;
        z = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        if (z > 1509949440) begin
            x = 0; y = 652032874; z = z - 1509949440;
        end else if (z < -1509949440) begin
            x = 0; y = -652032874; z = z + 1509949440;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = t;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint triple_prod(longint a, longint b, longint c);
        longint p;
        p = (a * b + (longint'(1) <<< 29)) >>> 30;
        return p * c;
    endfunction

    function automatic logic signed [Q_W-1:0] round_sat(longint q60);
        longint lim, v;
        lim = longint'(1) <<< OUT_FRAC_BITS;
        v = (q60 + (longint'(1) <<< (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[Q_W-1:0];
    endfunction

    function automatic t_quat rpy_to_quat(t_angles a);
        longint sr, cr, sp, cp, sy, cy;
        t_quat q;
        half_angle_sincos(a.roll, sr, cr);
        half_angle_sincos(a.pitch, sp, cp);
        half_angle_sincos(a.yaw, sy, cy);
        q.x = round_sat(triple_prod(sr, cp, cy) - triple_prod(cr, sp, sy));
        q.y = round_sat(triple_prod(cr, sp, cy) + triple_prod(sr, cp, sy));
        q.z = round_sat(triple_prod(cr, cp, sy) - triple_prod(sr, sp, cy));
        q.w = round_sat(triple_prod(cr, cp, cy) + triple_prod(sr, sp, sy));
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [ANG_W-1:0] rand_angle();
        int r;
        r = $urandom_range(99);
        if (r < 80) return ANG_W'($urandom_range(23040) - 11520);
        if (r < 90) return ANG_W'($urandom);
        // near the quadrant switch points
        return ANG_W'(($urandom_range(1) ? 11520 : -11520) + $urandom_range(8) - 4);
    endfunction

    task automatic add_item(int r, int p, int y, bit drain = 1'b0);
        t_angles a;
        a.roll = ANG_W'(r);
        a.pitch = ANG_W'(p);
        a.yaw = ANG_W'(y);
        a.drain = drain;
        pending_angles.push_back(a);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                t_angles a;
                a.roll = i_roll_angle;
                a.pitch = i_pitch_angle;
                a.yaw = i_yaw_angle;
                expected_quats.push_back(rpy_to_quat(a));
                void'(pending_angles.pop_front());
            end
            if ($urandom_range(199) == 0) calm_tx <= ~calm_tx;
            if (i_valid && o_stall) begin
                // stalled beat stays as it is
            end else if (send_gap > 0 && !calm_tx) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_angles.size() == 0 ||
                         (pending_angles[0].drain && expected_quats.size() != 0) ||
                         (pending_angles[0].drain && i_valid)) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_roll_angle <= pending_angles[0].roll;
                i_pitch_angle <= pending_angles[0].pitch;
                i_yaw_angle <= pending_angles[0].yaw;
                pending_angles[0].drain = 1'b0;
                send_gap <= pick_gap();
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_quats.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d", $time,
                             o_quat_x, o_quat_y, o_quat_z, o_quat_w);
                    errors++;
                end else begin
                    t_quat e;
                    e = expected_quats.pop_front();
                    if (o_quat_x !== e.x) begin
                        $display("%0t: quat_x expected %0d actual %0d", $time, e.x, o_quat_x);
                        errors++;
                    end
                    if (o_quat_y !== e.y) begin
                        $display("%0t: quat_y expected %0d actual %0d", $time, e.y, o_quat_y);
                        errors++;
                    end
                    if (o_quat_z !== e.z) begin
                        $display("%0t: quat_z expected %0d actual %0d", $time, e.z, o_quat_z);
                        errors++;
                    end
                    if (o_quat_w !== e.w) begin
                        $display("%0t: quat_w expected %0d actual %0d", $time, e.w, o_quat_w);
                        errors++;
                    end
                end
                beats_out++;
            end
            if ($urandom_range(199) == 0) calm_rx <= ~calm_rx;
            // one long hold-off so the pipeline fills and backs up the input
            if (!hold_done && beats_out >= 400) begin
                hold_done <= 1'b1;
                hold_left <= 300;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= (hold_left > 1);
            end else if (recv_gap > 0 && !calm_rx) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // directed: zero, extremes, full 15 bit patterns, quadrant edges
        add_item(0, 0, 0);
        add_item(11520, 0, 0);
        add_item(-11520, 0, 0);
        add_item(0, 11520, 0);
        add_item(0, -11520, 0);
        add_item(0, 0, 11520);
        add_item(0, 0, -11520);
        add_item(11520, 11520, 11520);
        add_item(-11520, -11520, -11520);
        add_item(16383, -16384, 16383);
        add_item(-16384, 16383, -16384);
        add_item(11521, -11521, 11521);
        add_item(11519, -11519, -11521);
        add_item(5760, 5760, 5760);
        add_item(-5760, 2880, -2880);
        add_item(1, -1, 1);
        add_item(5760, 5760, 0);
        add_item(0, 5760, -5760);
        for (int i = 0; i < 1650; i++) begin
            add_item(rand_angle(), rand_angle(), rand_angle(), i == 900);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_angles.size() == 0);
        @(posedge i_clk);
        wait (expected_quats.size() == 0);
        repeat (CORDIC_STEPS + 20) @(posedge i_clk);
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
design/erq_pkg.sv
design/erq_lane.sv
design/erq_merge.sv
design/euler_rpy_to_quaternion.sv
tb/sv/euler_rpy_to_quaternion_tb.sv
